### rtl/psqs_pkg.sv
// shared types and constants for the positional stack/queue store
`default_nettype none
package psqs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;

    localparam logic MODE_STACK = 1'b0;
    localparam logic MODE_QUEUE = 1'b1;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_FIND   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // what every cell does on a clock edge
    typedef enum logic [1:0] {
        CELL_HOLD        = 2'd0,
        CELL_SHIFT_BACK  = 2'd1,
        CELL_LOAD_AT     = 2'd2,
        CELL_SHIFT_FRONT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [DATA_W-1:0]   data;
    } t_cell_ctrl;

endpackage
`default_nettype wire

### rtl/psqs_cell.sv
// one storage cell of the ordered row
`default_nettype none
module psqs_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  wire                          i_clk,
    input  wire  psqs_pkg::t_cell_ctrl   i_ctrl,
    input  wire  [IDX_W-1:0]             i_idx,
    input  wire  [psqs_pkg::DATA_W-1:0]  i_left,
    input  wire  [psqs_pkg::DATA_W-1:0]  i_right,
    output logic [psqs_pkg::DATA_W-1:0]  o_val,
    output logic [psqs_pkg::DATA_W-1:0]  o_tap
);
    import psqs_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            CELL_SHIFT_BACK: begin
                // front cell's left input carries the pushed value
                n_val = i_left;
            end
            CELL_LOAD_AT: begin
                if (i_idx == MY_IDX) begin
                    n_val = i_ctrl.data;
                end
            end
            CELL_SHIFT_FRONT: begin
                if (MY_IDX >= i_idx) begin
                    n_val = i_right;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_tap = (i_idx == MY_IDX) ? r_val : '0;

endmodule
`default_nettype wire

### rtl/positional_stack_queue_store.sv
// top level: control, position checks and result register around the cell row
// An ordered store of signed 32-bit values held in a row of CAPACITY cells, position 1 at
// the front. Each cycle the whole row holds, shifts, loads or closes a gap at once, so one
// transaction is taken per clock and its result appears in the output register on the next
// cycle; a waiting result does not block the following transaction unless the output is
// stalled. The per-cycle cost is the position compare plus the OR tree that reads one cell
// out of the row. No clearing pass is needed after reset: cells beyond the length are never
// read. order_mode (0 stack, 1 queue) may only be written while the block is idle.
`default_nettype none
module positional_stack_queue_store #(
    parameter int CAPACITY = psqs_pkg::CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire                          i_cfg_wr_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [1:0]                   i_kind,
    input  wire  signed [psqs_pkg::DATA_W-1:0] i_operand,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [1:0]                   o_status,
    output logic signed [psqs_pkg::DATA_W-1:0] o_read_value,
    output logic [CNT_W-1:0]             o_length
);
    import psqs_pkg::*;

    logic              r_mode;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_read;
    logic [DATA_W-1:0] n_read;
    logic [CNT_W-1:0]  r_length;

    logic              w_accept;
    t_kind             w_kind;
    logic              w_full;
    logic              w_pos_ok;
    logic [IDX_W-1:0]  w_pos_idx;
    logic [IDX_W-1:0]  w_idx;
    t_cell_op          w_op;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_sel;

    logic [DATA_W-1:0] w_val [CAPACITY];
    logic [DATA_W-1:0] w_tap [CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_kind     = t_kind'(i_kind);
    assign w_full     = (r_count == CNT_W'(CAPACITY));

    // position must be 1..length; negative values fail on the sign bit
    assign w_pos_ok  = !i_operand[DATA_W-1] && (i_operand != '0)
                     && (i_operand[DATA_W-2:0] <= (DATA_W-1)'(r_count));
    assign w_pos_idx = i_operand[IDX_W-1:0] - IDX_W'(1);
    assign w_idx     = (w_kind == KIND_PUSH) ? r_count[IDX_W-1:0] : w_pos_idx;

    always_comb begin
        w_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_sel = w_sel | w_tap[k];
        end
    end

    always_comb begin
        w_op     = CELL_HOLD;
        n_status = ST_OK;
        n_read   = '0;
        n_count  = r_count;
        case (w_kind)
            KIND_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_op    = (r_mode == MODE_QUEUE) ? CELL_LOAD_AT : CELL_SHIFT_BACK;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_DELETE: begin
                if (!w_pos_ok) begin
                    n_status = ST_BADPOS;
                end else begin
                    w_op    = CELL_SHIFT_FRONT;
                    n_read  = w_sel;
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_FIND: begin
                if (!w_pos_ok) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_read = w_sel;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_ctrl = '{op: (w_accept ? w_op : CELL_HOLD), data: i_operand};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_front
            assign w_left = i_operand;
        end else begin : g_mid
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_back
            assign w_right = w_val[g];
        end else begin : g_inner
            assign w_right = w_val[g+1];
        end
        psqs_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (w_idx),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_val[g]),
            .o_tap   (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STACK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_read   <= n_read;
            r_length <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_read;
    assign o_length     = r_length;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_kind == KIND_PUSH) && !w_full
        |=> (o_length == $past(r_count) + CNT_W'(1)) && o_out_valid)
        else $error("push did not grow the length");

    a_find_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_kind == KIND_FIND) |=> r_count == $past(r_count))
        else $error("find changed the length");

    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_read_value == '0)
        else $error("failed transaction returned data");

endmodule
`default_nettype wire

### verif/positional_stack_queue_store_test.sv
// testbench for the positional stack/queue store: scoreboard class, drivers and checks
`default_nettype none
module positional_stack_queue_store_test;
    import psqs_pkg::*;

    localparam int STORE_DEPTH = CAPACITY_DEF;
    localparam int LEN_W = $clog2(STORE_DEPTH + 1);
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int HALF_PERIOD = 6;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] value;
        logic [LEN_W-1:0]  length;
    } t_answer;

    // mirror of the store contents, front at index 0
    class store_mirror;
        logic [DATA_W-1:0] contents[$];
        logic              mode;
        t_answer           pending[$];
        int unsigned       errors;

        function new();
            mode = MODE_STACK;
            errors = 0;
        endfunction

        function void note_item(logic [1:0] kind, logic [DATA_W-1:0] operand);
            t_answer ans;
            ans.status = ST_OK;
            ans.value = '0;
            case (kind)
                KIND_PUSH: begin
                    if (contents.size() >= STORE_DEPTH) begin
                        ans.status = ST_FULL;
                    end else if (mode == MODE_QUEUE) begin
                        contents.push_back(operand);
                    end else begin
                        contents.push_front(operand);
                    end
                end
                KIND_DELETE, KIND_FIND: begin
                    // negative positions compare as huge unsigned values
                    if (operand == 0 || operand > contents.size()) begin
                        ans.status = ST_BADPOS;
                    end else begin
                        ans.value = contents[operand - 1];
                        if (kind == KIND_DELETE) begin
                            contents.delete(operand - 1);
                        end
                    end
                end
                default: begin
                end
            endcase
            ans.length = LEN_W'(contents.size());
            pending.push_back(ans);
        endfunction

        function void check_result(logic [1:0] status, logic [DATA_W-1:0] value,
                                   logic [LEN_W-1:0] length);
            t_answer exp;
            if (pending.size() == 0) begin
                $display("%0t: result with no transaction waiting: status %0d value %h length %0d",
                         $time, status, value, length);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (status !== exp.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, exp.status, status);
                errors++;
            end
            if (value !== exp.value) begin
                $display("%0t: read_value mismatch: expected %h, actual %h",
                         $time, exp.value, value);
                errors++;
            end
            if (length !== exp.length) begin
                $display("%0t: length mismatch: expected %0d, actual %0d",
                         $time, exp.length, length);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic                     i_cfg_wr_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_kind;
    logic signed [DATA_W-1:0] i_operand;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_read_value;
    logic [LEN_W-1:0]         o_length;

    store_mirror mirror;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_off_req;

    positional_stack_queue_store #(
        .CAPACITY(STORE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_operand    (i_operand),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_length     (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // results are checked before the input of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                mirror.check_result(o_status, o_read_value, o_length);
            end
            if (i_in_valid && !o_in_stall) begin
                mirror.note_item(i_kind, i_operand);
            end
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!tx_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned pick_burst();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    // output side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (pick_burst()) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [DATA_W-1:0] operand);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_operand  <= operand;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait for a clock edge first so the last accepted transaction is already noted
    task automatic wait_for_answers();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_mode(input logic mode);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mirror.mode = mode;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_position();
        int unsigned n;
        int unsigned r;
        n = mirror.contents.size();
        r = $urandom_range(0, 99);
        if (r < 70 && n > 0) return $urandom_range(1, n);
        if (r < 80) return n + 1;
        if (r < 85) return 0;
        if (r < 92) return $urandom | 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic run_random(input int count, input int unsigned push_w,
                              input int unsigned del_w);
        int unsigned r;
        logic [1:0]  kind;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < push_w) kind = KIND_PUSH;
            else if (r < push_w + del_w) kind = KIND_DELETE;
            else if (r < 97) kind = KIND_FIND;
            else kind = KIND_UNUSED;
            if (kind == KIND_DELETE || kind == KIND_FIND) begin
                send_item(kind, pick_position());
            end else begin
                send_item(kind, pick_value());
            end
        end
    endtask

    initial begin
        mirror = new();
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_off_req = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_PUSH;
        i_operand     <= '0;
        i_out_stall   <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(MODE_STACK);
        // empty store, unused kind, extreme values and positions
        send_item(KIND_FIND, 32'd1);
        send_item(KIND_DELETE, 32'd1);
        send_item(KIND_UNUSED, 32'hFFFF_FFFF);
        send_item(KIND_PUSH, 32'h7FFF_FFFF);
        send_item(KIND_PUSH, 32'h8000_0000);
        send_item(KIND_PUSH, 32'h0000_0000);
        send_item(KIND_PUSH, 32'hFFFF_FFFF);
        send_item(KIND_FIND, 32'd1);
        send_item(KIND_FIND, 32'd4);
        send_item(KIND_FIND, 32'd5);
        send_item(KIND_FIND, 32'd0);
        send_item(KIND_FIND, 32'hFFFF_FFFF);
        send_item(KIND_FIND, 32'h8000_0000);
        send_item(KIND_FIND, 32'h7FFF_FFFF);
        send_item(KIND_DELETE, 32'd5);
        send_item(KIND_DELETE, 32'd2);
        send_item(KIND_DELETE, 32'd3);
        send_item(KIND_DELETE, 32'd1);
        send_item(KIND_FIND, 32'd1);
        wait_for_answers();

        // mode change with an element still held
        write_mode(MODE_QUEUE);
        send_item(KIND_PUSH, 32'd5);
        send_item(KIND_PUSH, 32'hAAAA_5555);
        send_item(KIND_FIND, 32'd3);
        send_item(KIND_DELETE, 32'd1);
        send_item(KIND_UNUSED, 32'h5555_AAAA);
        run_random(120, 45, 25);
        wait_for_answers();

        // back to back with a long output hold-off; push-heavy, so the store fills and pushes meet a full store
        write_mode(MODE_STACK);
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_off_req = 1'b1;
        run_random(120, 85, 5);
        wait_for_answers();

        write_mode(MODE_QUEUE);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(120, 20, 60);
        wait_for_answers();

        write_mode(MODE_STACK);
        run_random(100, 40, 30);
        wait_for_answers();

        write_mode(MODE_QUEUE);
        run_random(90, 80, 10);
        wait_for_answers();

        if (mirror.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
